>>> design/sbsm_pkg.sv
// sbsm_pkg: shared types and constants for the serial bank switch mapper
// used by sbsm_regs, sbsm_xlate and serial_bank_switch_mapper; no dependencies
package sbsm_pkg;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_PATTERN = 2'd2
	} op_t;

	// targets of a completed serial write, from bus address bits 14:13
	localparam logic [1:0] TGT_CONTROL  = 2'd0;
	localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
	localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
	localparam logic [1:0] TGT_PRG_BANK = 2'd3;

	// prg mode codes
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

	// configuration register indexes (paddr bit 2)
	localparam logic REG_PRG_COUNT = 1'b0;
	localparam logic REG_CHR_COUNT = 1'b1;

	localparam int PRG_COUNT_W = 6;
	localparam int CHR_COUNT_W = 5;
	localparam int OFFSET_W    = 19;

	localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 6'd16;
	localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 5'd0;

	typedef struct packed {
		logic [1:0] mirror;
		logic [1:0] prg_mode;
		logic       chr_mode;
		logic [4:0] chr_low;
		logic [4:0] chr_high;
		logic [3:0] prg_bank;
	} map_state_t;

endpackage

>>> design/serial_bank_switch_mapper.sv
// serial_bank_switch_mapper: top level, request pipeline and configuration port
// depends on sbsm_pkg, sbsm_regs and sbsm_xlate
//
// Each request carries op, bus_addr and write_data. A cpu write (op 0) at
// 0x8000 and above feeds the serial load register; a cpu read (op 1) or a
// ppu pattern fetch (op 2) is translated into a memory offset. Every request
// gives exactly one result: rom_offset, mapped and the mirroring mode in
// force after the request.
// Channels use valid/stall; a request is taken when in_valid is high and
// in_stall is low, a result when out_valid is high and out_stall is low.
// out_valid rises once an accepted request has gone through an input register,
// then one pass through the mapper registers and translation into the
// result register. One request per cycle is sustained; in_stall rises only
// when both registers are full and out_stall holds the result register.
// Reset clears both stages and loads the power-up mapper state (prg mode 3,
// chr bank 1 = 1) and bank counts of 16 program banks and pattern RAM.
// The two bank-count registers sit at byte addresses 0 and 4 of the APB port;
// the user must write them only while no request is in flight; not enforced.
module serial_bank_switch_mapper #(
	parameter int MAX_PRG_BANKS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] bus_addr,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [18:0] rom_offset,
	output logic        mapped,
	output logic [1:0]  mirror_mode,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [sbsm_pkg::PRG_COUNT_W-1:0] prg_bank_count_q;
	logic [sbsm_pkg::CHR_COUNT_W-1:0] chr_bank_count_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic        valid_s2;
	logic [18:0] offset_s2;
	logic        mapped_s2;
	logic [1:0]  mirror_s2;

	logic                 advance;
	logic                 take_in;
	logic                 step;
	sbsm_pkg::map_state_t map_state;
	logic [1:0]           mirror_next;
	logic [18:0]          xl_offset;
	logic                 xl_mapped;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q <= sbsm_pkg::PRG_COUNT_RESET;
			chr_bank_count_q <= sbsm_pkg::CHR_COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				sbsm_pkg::REG_PRG_COUNT:
					prg_bank_count_q <= pwdata[sbsm_pkg::PRG_COUNT_W-1:0];
				sbsm_pkg::REG_CHR_COUNT:
					chr_bank_count_q <= pwdata[sbsm_pkg::CHR_COUNT_W-1:0];
				default: prg_bank_count_q <= prg_bank_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sbsm_pkg::REG_PRG_COUNT: prdata = {26'd0, prg_bank_count_q};
			sbsm_pkg::REG_CHR_COUNT: prdata = {27'd0, chr_bank_count_q};
			default: prdata = '0;
		endcase
	end

	// request pipeline
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1   <= op;
			addr_s1 <= bus_addr;
			data_s1 <= write_data;
		end
	end

	sbsm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (step),
		.op          (op_s1),
		.bus_addr    (addr_s1),
		.write_data  (data_s1),
		.state       (map_state),
		.mirror_next (mirror_next)
	);

	sbsm_xlate #(
		.MAX_PRG_BANKS (MAX_PRG_BANKS)
	) u_xlate (
		.state          (map_state),
		.prg_bank_count (prg_bank_count_q),
		.chr_bank_count (chr_bank_count_q),
		.op             (op_s1),
		.bus_addr       (addr_s1),
		.rom_offset     (xl_offset),
		.mapped         (xl_mapped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			offset_s2 <= xl_offset;
			mapped_s2 <= xl_mapped;
			mirror_s2 <= mirror_next;
		end
	end

	assign out_valid   = valid_s2;
	assign rom_offset  = offset_s2;
	assign mapped      = mapped_s2;
	assign mirror_mode = mirror_s2;

endmodule

>>> design/sbsm_regs.sv
// sbsm_regs: serial load register and the bank/mode registers it fills
// depends on sbsm_pkg
module sbsm_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic [1:0]            op,
	input  logic [15:0]           bus_addr,
	input  logic [7:0]            write_data,
	output sbsm_pkg::map_state_t  state,
	output logic [1:0]            mirror_next
);

	logic [4:0]           shift_value_q;
	logic [2:0]           shift_count_q;
	sbsm_pkg::map_state_t state_q;

	logic [4:0]           shift_value_d;
	logic [2:0]           shift_count_d;
	sbsm_pkg::map_state_t state_d;
	logic [4:0]           full_value;
	logic                 do_write;

	assign do_write = cmd_valid && (op == sbsm_pkg::OP_WRITE) && bus_addr[15];

	always_comb begin
		shift_value_d = shift_value_q;
		shift_count_d = shift_count_q;
		state_d       = state_q;
		full_value    = shift_value_q;
		full_value[shift_count_q] = write_data[0];
		if (do_write) begin
			if (write_data[7]) begin
				shift_value_d  = 5'd0;
				shift_count_d  = 3'd0;
				state_d.prg_mode = sbsm_pkg::PRG_MODE_FIX_LAST;
			end else if (shift_count_q == 3'd4) begin
				// fifth bit: commit the assembled value
				shift_value_d = 5'd0;
				shift_count_d = 3'd0;
				unique case (bus_addr[14:13])
					sbsm_pkg::TGT_CONTROL: begin
						state_d.mirror   = full_value[1:0];
						state_d.prg_mode = full_value[3:2];
						state_d.chr_mode = full_value[4];
					end
					sbsm_pkg::TGT_CHR_LOW:  state_d.chr_low  = full_value;
					sbsm_pkg::TGT_CHR_HIGH: state_d.chr_high = full_value;
					sbsm_pkg::TGT_PRG_BANK: state_d.prg_bank = full_value[3:0];
					default: state_d = state_q;
				endcase
			end else begin
				shift_value_d = full_value;
				shift_count_d = shift_count_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q    <= 5'd0;
			shift_count_q    <= 3'd0;
			state_q.mirror   <= 2'd0;
			state_q.prg_mode <= sbsm_pkg::PRG_MODE_FIX_LAST;
			state_q.chr_mode <= 1'b0;
			state_q.chr_low  <= 5'd0;
			state_q.chr_high <= 5'd1;
			state_q.prg_bank <= 4'd0;
		end else begin
			shift_value_q <= shift_value_d;
			shift_count_q <= shift_count_d;
			state_q       <= state_d;
		end
	end

	assign state       = state_q;
	assign mirror_next = state_d.mirror;

endmodule

>>> design/sbsm_xlate.sv
// sbsm_xlate: combinational translation of cpu reads and ppu pattern fetches
// into program or pattern memory offsets; depends on sbsm_pkg
module sbsm_xlate #(
	parameter int MAX_PRG_BANKS = 32
) (
	input  sbsm_pkg::map_state_t                  state,
	input  logic [sbsm_pkg::PRG_COUNT_W-1:0]      prg_bank_count,
	input  logic [sbsm_pkg::CHR_COUNT_W-1:0]      chr_bank_count,
	input  logic [1:0]                            op,
	input  logic [15:0]                           bus_addr,
	output logic [sbsm_pkg::OFFSET_W-1:0]         rom_offset,
	output logic                                  mapped
);

	localparam logic [sbsm_pkg::PRG_COUNT_W-1:0] MaxBanks =
		sbsm_pkg::PRG_COUNT_W'(MAX_PRG_BANKS);

	logic [sbsm_pkg::PRG_COUNT_W-1:0] eff_banks;
	logic                             big_prg;
	logic [4:0]                       prg_bank_sel;
	logic [18:0]                      prg_off;
	logic [19:0]                      prg_size;
	logic [18:0]                      prg_mask;
	logic [4:0]                       chr_low;
	logic [16:0]                      chr_off;
	logic [17:0]                      chr_size;
	logic [16:0]                      chr_mask;
	logic [18:0]                      chr_result;

	always_comb begin
		if (prg_bank_count == '0) begin
			eff_banks = sbsm_pkg::PRG_COUNT_W'(1);
		end else if (prg_bank_count > MaxBanks) begin
			eff_banks = MaxBanks;
		end else begin
			eff_banks = prg_bank_count;
		end
	end

	assign big_prg = eff_banks > sbsm_pkg::PRG_COUNT_W'(16);

	// program side
	always_comb begin
		prg_bank_sel = {big_prg & state.chr_low[4], state.prg_bank};
		if (state.prg_mode == sbsm_pkg::PRG_MODE_FIX_FIRST) begin
			if (!bus_addr[14]) begin
				prg_bank_sel[3:0] = 4'd0;
			end
		end else if (state.prg_mode == sbsm_pkg::PRG_MODE_FIX_LAST) begin
			if (bus_addr[14]) begin
				prg_bank_sel[3:0] = 4'hF;
			end
		end
		if (!state.prg_mode[1]) begin
			prg_off = {prg_bank_sel[4:1], bus_addr[14:0]};
		end else begin
			prg_off = {prg_bank_sel, bus_addr[13:0]};
		end
		prg_size = {eff_banks, 14'd0};
		prg_mask = 19'(prg_size - 20'd1);
	end

	// pattern side
	always_comb begin
		chr_low = state.chr_low;
		if (big_prg) begin
			chr_low[4] = 1'b0;
		end
		if (!state.chr_mode) begin
			chr_off = {chr_low[4:1], bus_addr[12:0]};
		end else if (!bus_addr[12]) begin
			chr_off = {chr_low, bus_addr[11:0]};
		end else begin
			chr_off = {state.chr_high, bus_addr[11:0]};
		end
		chr_size = {chr_bank_count, 13'd0};
		chr_mask = 17'(chr_size - 18'd1);
		if (chr_bank_count == '0) begin
			chr_result = {6'd0, bus_addr[12:0]};
		end else begin
			chr_result = {2'd0, chr_off & chr_mask};
		end
	end

	always_comb begin
		rom_offset = '0;
		mapped     = 1'b0;
		case (op)
			sbsm_pkg::OP_READ: begin
				if (bus_addr[15]) begin
					rom_offset = prg_off & prg_mask;
					mapped     = 1'b1;
				end
			end
			sbsm_pkg::OP_PATTERN: begin
				if (bus_addr[15:13] == 3'd0) begin
					rom_offset = chr_result;
					mapped     = 1'b1;
				end
			end
			default: begin
				rom_offset = '0;
				mapped     = 1'b0;
			end
		endcase
	end

endmodule
